// ----- hw/rtl/ilha_pkg.sv -----
// ----------------------------------------------------------------------------
// ilha_pkg
// shared types and constants of the boundary-tag heap allocator
// ----------------------------------------------------------------------------
package ilha_pkg;

  localparam int WORD_W         = 32;
  localparam int HEAP_BYTES_DEF = 65536;
  localparam int MIN_BLOCK      = 16;
  localparam int PROLOGUE_BP    = 8;
  localparam int MIN_EXT_RESET  = 4096;
  localparam int CFG_W          = 17;
  localparam int REQ_W          = 17;
  localparam int ADDR_W         = 16;
  localparam int GRANT_W        = 17;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_ZERO     = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    ST_INIT0,
    ST_INIT1,
    ST_INIT2,
    ST_INIT3,
    ST_INIT4,
    ST_IDLE,
    ST_FIT_RD,
    ST_FIT_EV,
    ST_FIT_CHK,
    ST_GROW,
    ST_GROW_H,
    ST_GROW_F,
    ST_GROW_E,
    ST_MRG_RD,
    ST_MRG_PF,
    ST_MRG_NH,
    ST_MRG_WH,
    ST_MRG_WF,
    ST_PLC_H,
    ST_PLC_F,
    ST_PLC_RH,
    ST_PLC_RF,
    ST_VAL_RD,
    ST_VAL_EV,
    ST_FREE_H,
    ST_FREE_F,
    ST_DONE
  } state_t;

endpackage

// ----- hw/rtl/implicit_list_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// implicit_list_heap_allocator
// a zero size request goes straight to the result; allocate walks the heap
//   blocks by next-fit from the rover (wrapping to the prologue at the
//   epilogue), grows the heap at the break when no block fits (merging the
//   new space with a free tail block), then places the block
// free: walks the blocks from the prologue to check the address, then marks
//   the block free and merges it with its neighbours
// one item at a time; all heap accesses share the single memory port
// reset: writes prologue, epilogue and the first free chunk, during
//   which no transaction is taken; the rest of the heap stays unwritten
// ----------------------------------------------------------------------------
module implicit_list_heap_allocator #(
  parameter int HEAP_BYTES = ilha_pkg::HEAP_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration: min_extend_bytes
  input  logic                       cfg_wr_en,
  input  logic [ilha_pkg::CFG_W-1:0] cfg_wr_data,
  // request side
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [39:0]                s_axis_tdata,  // request_bytes, payload_addr
  input  logic [0:0]                 s_axis_tuser,  // mode
  // result side
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [39:0]                m_axis_tdata   // result_addr, granted_bytes, status
);

  // byte address bits of the heap, and a width that holds any size or offset
  localparam int HA_W  = $clog2(HEAP_BYTES);
  localparam int IDX_W = HA_W - 2;
  localparam int SW    = (HA_W + 1 > 18) ? HA_W + 1 : 18;
  // reset chunk fits only if the heap holds prologue plus the first chunk
  localparam bit INIT_FITS = (HEAP_BYTES >= 16 + ilha_pkg::MIN_EXT_RESET);
  localparam int INIT_BRK  = INIT_FITS ? 16 + ilha_pkg::MIN_EXT_RESET : 16;

  ilha_pkg::state_t state, state_next;

  logic [SW-1:0]               bp, bp_next;
  logic [SW-1:0]               size, size_next;
  logic [SW-1:0]               asize, asize_next;
  logic [SW-1:0]               rover, rover_next;
  logic [SW-1:0]               brk, brk_next;
  logic [SW-1:0]               psize, psize_next;
  logic                        pa, pa_next;
  logic                        ret_alloc, ret_alloc_next;
  logic [ilha_pkg::ADDR_W-1:0] faddr, faddr_next;
  logic [ilha_pkg::CFG_W-1:0]  min_ext;
  logic [ilha_pkg::ADDR_W-1:0] res_addr, res_addr_next;
  logic [ilha_pkg::GRANT_W-1:0] res_gr, res_gr_next;
  ilha_pkg::status_t           res_st, res_st_next;
  logic                        out_load;

  // memory access
  logic                        mem_we;
  logic [SW-1:0]               mem_addr;
  logic [ilha_pkg::WORD_W-1:0] mem_wdata;
  logic [ilha_pkg::WORD_W-1:0] mem_rdata;

  // input fields
  logic                        in_mode;
  logic [ilha_pkg::REQ_W-1:0]  in_req;
  logic [ilha_pkg::ADDR_W-1:0] in_addr;

  assign in_mode = s_axis_tuser[0];
  assign in_req  = s_axis_tdata[16:0];
  assign in_addr = s_axis_tdata[32:17];

  ilha_heap_ram #(.IDX_W(IDX_W)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .idx   (mem_addr[HA_W-1:2]),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // header / footer fields of the word just read
  logic [SW-1:0] rd_size;
  logic          rd_alloc;
  assign rd_size  = {mem_rdata[SW-1:3], 3'b000};
  assign rd_alloc = mem_rdata[0];

  // block size asked for, and growth amount
  logic [17:0]   req_round;
  logic [SW-1:0] req_asize;
  logic [17:0]   ext_round;
  logic [SW-1:0] grow_bytes;
  logic [SW:0]   grow_end;
  logic          no_room;

  assign req_round  = ({1'b0, in_req} + 18'd15) & ~18'd7;
  assign req_asize  = (in_req <= ilha_pkg::REQ_W'(8)) ? SW'(ilha_pkg::MIN_BLOCK)
                                                      : SW'(req_round);
  assign ext_round  = ({1'b0, min_ext} + 18'd7) & ~18'd7;
  assign grow_bytes = (asize > SW'(ext_round)) ? asize : SW'(ext_round);
  assign grow_end   = {1'b0, brk} + {1'b0, grow_bytes};
  assign no_room    = grow_end > (SW+1)'(HEAP_BYTES);

  // placement split
  logic [SW-1:0] rest;
  logic          split;
  logic [SW-1:0] gsize;
  assign rest  = size - asize;
  assign split = rest >= SW'(ilha_pkg::MIN_BLOCK);
  assign gsize = split ? asize : size;

  // fit test on the header just read
  logic fit_hit;
  assign fit_hit = !rd_alloc && (rd_size >= asize);

  // neighbour addresses during merge
  logic [SW-1:0] prev_bp;
  logic [SW-1:0] nxt_bp;
  assign prev_bp = bp - psize;
  assign nxt_bp  = bp + size;

  assign s_axis_tready = (state == ilha_pkg::ST_IDLE);
  assign out_load      = (state == ilha_pkg::ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_next     = state;
    bp_next        = bp;
    size_next      = size;
    asize_next     = asize;
    rover_next     = rover;
    brk_next       = brk;
    psize_next     = psize;
    pa_next        = pa;
    ret_alloc_next = ret_alloc;
    faddr_next     = faddr;
    res_addr_next  = res_addr;
    res_gr_next    = res_gr;
    res_st_next    = res_st;
    mem_we         = 1'b0;
    mem_addr       = bp - SW'(4);
    mem_wdata      = '0;

    unique case (state)
      // prologue header and footer, then the first chunk or a bare epilogue
      ilha_pkg::ST_INIT0: begin
        mem_we     = 1'b1;
        mem_addr   = SW'(4);
        mem_wdata  = 32'(ilha_pkg::PROLOGUE_BP + 1);
        state_next = ilha_pkg::ST_INIT1;
      end
      ilha_pkg::ST_INIT1: begin
        mem_we     = 1'b1;
        mem_addr   = SW'(8);
        mem_wdata  = 32'(ilha_pkg::PROLOGUE_BP + 1);
        state_next = ilha_pkg::ST_INIT2;
      end
      ilha_pkg::ST_INIT2: begin
        mem_we     = 1'b1;
        mem_addr   = SW'(12);
        mem_wdata  = INIT_FITS ? 32'(ilha_pkg::MIN_EXT_RESET) : 32'(1);
        state_next = INIT_FITS ? ilha_pkg::ST_INIT3 : ilha_pkg::ST_IDLE;
      end
      ilha_pkg::ST_INIT3: begin
        mem_we     = 1'b1;
        mem_addr   = SW'(INIT_BRK - 8);
        mem_wdata  = 32'(ilha_pkg::MIN_EXT_RESET);
        state_next = ilha_pkg::ST_INIT4;
      end
      ilha_pkg::ST_INIT4: begin
        mem_we     = 1'b1;
        mem_addr   = SW'(INIT_BRK - 4);
        mem_wdata  = 32'(1);
        state_next = ilha_pkg::ST_IDLE;
      end

      ilha_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          res_addr_next = '0;
          res_gr_next   = '0;
          res_st_next   = ilha_pkg::STATUS_OK;
          if (in_mode == ilha_pkg::MODE_FREE) begin
            faddr_next = in_addr;
            bp_next    = SW'(ilha_pkg::PROLOGUE_BP);
            state_next = ilha_pkg::ST_VAL_RD;
          end else if (in_req == '0) begin
            res_st_next = ilha_pkg::STATUS_ZERO;
            state_next  = ilha_pkg::ST_DONE;
          end else begin
            asize_next = req_asize;
            bp_next    = rover;
            state_next = ilha_pkg::ST_FIT_RD;
          end
        end
      end

      // next-fit walk from the rover
      ilha_pkg::ST_FIT_RD: begin
        state_next = ilha_pkg::ST_FIT_EV;
      end
      ilha_pkg::ST_FIT_EV, ilha_pkg::ST_FIT_CHK: begin
        if (state == ilha_pkg::ST_FIT_CHK && rd_size == '0) begin
          // epilogue: wrap to the prologue
          bp_next    = SW'(ilha_pkg::PROLOGUE_BP);
          state_next = (rover == SW'(ilha_pkg::PROLOGUE_BP)) ? ilha_pkg::ST_GROW
                                                              : ilha_pkg::ST_FIT_RD;
        end else if (state == ilha_pkg::ST_FIT_CHK && bp == rover) begin
          state_next = ilha_pkg::ST_GROW;
        end else if (fit_hit) begin
          rover_next = bp;
          size_next  = rd_size;
          state_next = ilha_pkg::ST_PLC_H;
        end else begin
          bp_next    = bp + rd_size;
          mem_addr   = bp + rd_size - SW'(4);
          state_next = ilha_pkg::ST_FIT_CHK;
        end
      end

      // heap growth at the break
      ilha_pkg::ST_GROW: begin
        if (no_room) begin
          res_st_next = ilha_pkg::STATUS_NO_SPACE;
          state_next  = ilha_pkg::ST_DONE;
        end else begin
          bp_next    = brk;
          size_next  = grow_bytes;
          state_next = ilha_pkg::ST_GROW_H;
        end
      end
      ilha_pkg::ST_GROW_H: begin
        mem_we     = 1'b1;
        mem_addr   = bp - SW'(4);
        mem_wdata  = 32'(size);
        state_next = ilha_pkg::ST_GROW_F;
      end
      ilha_pkg::ST_GROW_F: begin
        mem_we     = 1'b1;
        mem_addr   = bp + size - SW'(8);
        mem_wdata  = 32'(size);
        state_next = ilha_pkg::ST_GROW_E;
      end
      ilha_pkg::ST_GROW_E: begin
        mem_we         = 1'b1;
        mem_addr       = bp + size - SW'(4);
        mem_wdata      = 32'(1);
        brk_next       = bp + size;
        ret_alloc_next = 1'b1;
        state_next     = ilha_pkg::ST_MRG_RD;
      end

      // coalesce the free block at bp with its neighbours
      ilha_pkg::ST_MRG_RD: begin
        mem_addr   = bp - SW'(8);
        state_next = ilha_pkg::ST_MRG_PF;
      end
      ilha_pkg::ST_MRG_PF: begin
        psize_next = rd_size;
        pa_next    = rd_alloc;
        mem_addr   = bp + size - SW'(4);
        state_next = ilha_pkg::ST_MRG_NH;
      end
      ilha_pkg::ST_MRG_NH: begin
        if (pa && rd_alloc) begin
          if (ret_alloc) begin
            state_next = ilha_pkg::ST_PLC_H;
          end else begin
            state_next = ilha_pkg::ST_DONE;
          end
        end else begin
          state_next = ilha_pkg::ST_MRG_WH;
          if (pa) begin
            if (rover == nxt_bp) rover_next = bp;
            size_next = size + rd_size;
          end else if (rd_alloc) begin
            if (rover == bp) rover_next = prev_bp;
            bp_next   = prev_bp;
            size_next = size + psize;
          end else begin
            if (rover == bp || rover == nxt_bp) rover_next = prev_bp;
            bp_next   = prev_bp;
            size_next = size + psize + rd_size;
          end
        end
      end
      ilha_pkg::ST_MRG_WH: begin
        mem_we     = 1'b1;
        mem_addr   = bp - SW'(4);
        mem_wdata  = 32'(size);
        state_next = ilha_pkg::ST_MRG_WF;
      end
      ilha_pkg::ST_MRG_WF: begin
        mem_we     = 1'b1;
        mem_addr   = bp + size - SW'(8);
        mem_wdata  = 32'(size);
        state_next = ret_alloc ? ilha_pkg::ST_PLC_H : ilha_pkg::ST_DONE;
      end

      // mark allocated, split off a free remainder if large enough
      ilha_pkg::ST_PLC_H: begin
        mem_we     = 1'b1;
        mem_addr   = bp - SW'(4);
        mem_wdata  = 32'(gsize) | 32'(1);
        state_next = ilha_pkg::ST_PLC_F;
      end
      ilha_pkg::ST_PLC_F: begin
        mem_we        = 1'b1;
        mem_addr      = bp + gsize - SW'(8);
        mem_wdata     = 32'(gsize) | 32'(1);
        res_addr_next = bp[ilha_pkg::ADDR_W-1:0];
        res_gr_next   = gsize[ilha_pkg::GRANT_W-1:0];
        res_st_next   = ilha_pkg::STATUS_OK;
        state_next    = split ? ilha_pkg::ST_PLC_RH : ilha_pkg::ST_DONE;
      end
      ilha_pkg::ST_PLC_RH: begin
        mem_we     = 1'b1;
        mem_addr   = bp + asize - SW'(4);
        mem_wdata  = 32'(rest);
        state_next = ilha_pkg::ST_PLC_RF;
      end
      ilha_pkg::ST_PLC_RF: begin
        mem_we     = 1'b1;
        mem_addr   = bp + size - SW'(8);
        mem_wdata  = 32'(rest);
        state_next = ilha_pkg::ST_DONE;
      end

      // free: walk the block list to check the address
      ilha_pkg::ST_VAL_RD: begin
        state_next = ilha_pkg::ST_VAL_EV;
      end
      ilha_pkg::ST_VAL_EV: begin
        if (rd_size == '0 || bp > SW'(faddr)) begin
          state_next = ilha_pkg::ST_DONE;
        end else if (bp == SW'(faddr)) begin
          if (bp != SW'(ilha_pkg::PROLOGUE_BP) && rd_alloc) begin
            size_next  = rd_size;
            state_next = ilha_pkg::ST_FREE_H;
          end else begin
            state_next = ilha_pkg::ST_DONE;
          end
        end else begin
          bp_next  = bp + rd_size;
          mem_addr = bp + rd_size - SW'(4);
        end
      end
      ilha_pkg::ST_FREE_H: begin
        mem_we     = 1'b1;
        mem_addr   = bp - SW'(4);
        mem_wdata  = 32'(size);
        state_next = ilha_pkg::ST_FREE_F;
      end
      ilha_pkg::ST_FREE_F: begin
        mem_we         = 1'b1;
        mem_addr       = bp + size - SW'(8);
        mem_wdata      = 32'(size);
        ret_alloc_next = 1'b0;
        state_next     = ilha_pkg::ST_MRG_RD;
      end

      ilha_pkg::ST_DONE: begin
        if (out_load) state_next = ilha_pkg::ST_IDLE;
      end

      default: state_next = ilha_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ilha_pkg::ST_INIT0;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rover         <= SW'(ilha_pkg::PROLOGUE_BP);
      brk           <= SW'(INIT_BRK);
      min_ext       <= ilha_pkg::CFG_W'(ilha_pkg::MIN_EXT_RESET);
      m_axis_tvalid <= 1'b0;
    end else begin
      rover <= rover_next;
      brk   <= brk_next;
      if (cfg_wr_en) min_ext <= cfg_wr_data;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    bp        <= bp_next;
    size      <= size_next;
    asize     <= asize_next;
    psize     <= psize_next;
    pa        <= pa_next;
    ret_alloc <= ret_alloc_next;
    faddr     <= faddr_next;
    res_addr  <= res_addr_next;
    res_gr    <= res_gr_next;
    res_st    <= res_st_next;
    if (out_load) begin
      m_axis_tdata <= {5'b0, res_st, res_gr, res_addr};
    end
  end

endmodule

// ----- hw/rtl/ilha_heap_ram.sv -----
// ----------------------------------------------------------------------------
// ilha_heap_ram
// single-port heap word memory, registered read data
// ----------------------------------------------------------------------------
module ilha_heap_ram #(
  parameter int IDX_W = 14
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [IDX_W-1:0]            idx,
  input  logic [ilha_pkg::WORD_W-1:0] wdata,
  output logic [ilha_pkg::WORD_W-1:0] rdata
);

  logic [ilha_pkg::WORD_W-1:0] mem [2**IDX_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx] <= wdata;
    end
    rdata <= mem[idx];
  end

endmodule
